@@ hw/rtl/wac_pkg.sv @@
// Package for the weekday anniversary counter.
// Holds the job word passed from the front end to the scanner, constants
// and the small arithmetic helpers. Depends on nothing.
package wac_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int WD_W    = 3;
  localparam int SUM_W   = 11;

  localparam logic [YEAR_W-1:0]  MAX_YEAR = 14'd9999;
  localparam logic [12:0]        RECIP_100 = 13'd5243;
  localparam int                 RECIP_SHIFT = 19;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  typedef struct packed {
    logic              ok;
    logic [WD_W-1:0]   wd;
    logic              feb29;
    logic              early;
    logic [YEAR_W-1:0] year;
    logic [YEAR_W-1:0] last;
    logic [6:0]        c100;
    logic [8:0]        c400;
  } job_t;

  // Month term of Zeller's congruence, floor(13 * (m + 1) / 5), where
  // January and February count as months 13 and 14.
  function automatic logic [5:0] month_term(input logic [MONTH_W-1:0] m);
    logic [5:0] r;
    case (m)
      4'd1:    r = 6'd36;
      4'd2:    r = 6'd39;
      4'd3:    r = 6'd10;
      4'd4:    r = 6'd13;
      4'd5:    r = 6'd15;
      4'd6:    r = 6'd18;
      4'd7:    r = 6'd20;
      4'd8:    r = 6'd23;
      4'd9:    r = 6'd26;
      4'd10:   r = 6'd28;
      4'd11:   r = 6'd31;
      4'd12:   r = 6'd33;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  // Residue modulo 7 by folding octal digits, since 8 is 1 modulo 7.
  function automatic logic [WD_W-1:0] mod7(input logic [SUM_W-1:0] x);
    logic [4:0] a;
    logic [3:0] b;
    a = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]) + 5'(x[10:9]);
    b = 4'(a[2:0]) + 4'(a[4:3]);
    return (b >= 4'd7) ? 3'(b - 4'd7) : b[2:0];
  endfunction

endpackage

@@ hw/rtl/weekday_anniversary_counter.sv @@
// Top level of the weekday anniversary counter.
// Ties the front end, the job queue and the scanner together. Depends on wac_pkg.
//
// Input side is a queue: a word (date_year, date_month, date_day, last_year)
// is taken when push is high and full is low. Result side is a queue too:
// while empty is low the oldest result (date_ok, day_of_week, match_count)
// sits on the ports and is taken when pop is high.
// The front end checks the date and computes the weekday in its DIV and SUM
// states, then hands a job to a two-entry queue. The scanner steps one
// candidate year per cycle up to last_year, capped at 9999; an invalid date
// skips the scan. The front end takes a new word once its job is in the
// queue, so it can check one word while the scanner works on earlier ones.
// The result stays in its register while pop is low; the scanner then waits,
// the queue fills and full stays high while the front end keeps its word.
// Reset empties the queue and the result register and idles both engines.
module weekday_anniversary_counter import wac_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [YEAR_W-1:0]  date_year,
  input  logic [MONTH_W-1:0] date_month,
  input  logic [DAY_W-1:0]   date_day,
  input  logic [YEAR_W-1:0]  last_year,
  output logic               empty,
  input  logic               pop,
  output logic               date_ok,
  output logic [WD_W-1:0]    day_of_week,
  output logic [YEAR_W-1:0]  match_count
);

  job_t front_job;
  job_t queue_job;
  logic job_push;
  logic job_full;
  logic job_pop;
  logic job_empty;

  wac_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .date_year  (date_year),
    .date_month (date_month),
    .date_day   (date_day),
    .last_year  (last_year),
    .job_push   (job_push),
    .job_full   (job_full),
    .job        (front_job)
  );

  wac_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (front_job),
    .full     (job_full),
    .pop      (job_pop),
    .pop_job  (queue_job),
    .empty    (job_empty)
  );

  wac_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .job_empty   (job_empty),
    .job_pop     (job_pop),
    .job         (queue_job),
    .empty       (empty),
    .pop         (pop),
    .date_ok     (date_ok),
    .day_of_week (day_of_week),
    .match_count (match_count)
  );

endmodule

@@ hw/rtl/wac_front.sv @@
// Front end: accepts a date word, checks it and computes its weekday.
// Produces one job word for the scanner. Depends on wac_pkg.
module wac_front import wac_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [YEAR_W-1:0]  date_year,
  input  logic [MONTH_W-1:0] date_month,
  input  logic [DAY_W-1:0]   date_day,
  input  logic [YEAR_W-1:0]  last_year,
  output logic               job_push,
  input  logic               job_full,
  output job_t               job
);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_DIV  = 4'b0010,
    F_SUM  = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_t;

  fstate_t state;
  fstate_t state_next;

  logic [YEAR_W-1:0]  year;
  logic [MONTH_W-1:0] month;
  logic [DAY_W-1:0]   day;
  logic [YEAR_W-1:0]  last;
  logic [7:0]         quot;
  logic [SUM_W-1:0]   sum;
  logic               ok;
  logic [6:0]         c100;
  logic [8:0]         c400;

  logic [26:0]        prod;
  logic [6:0]         k;
  logic [6:0]         ks;
  logic [7:0]         js;
  logic               early;
  logic               feb29;
  logic               leap;
  logic               ok_next;
  logic [SUM_W-1:0]   sum_next;

  assign full = (state != F_IDLE);
  assign prod = 27'(year) * 27'(RECIP_100);
  assign early = (month <= MONTH_FEB);
  assign feb29 = (month == MONTH_FEB) && (day == 5'd29);

  always_comb begin
    k = 7'(year - 14'({6'd0, quot} * 14'd100));
    leap = (k == 7'd0) ? (quot[1:0] == 2'd0) : (k[1:0] == 2'd0);
    if (early && (k == 7'd0)) begin
      ks = 7'd99;
      js = quot - 8'd1;
    end else if (early) begin
      ks = k - 7'd1;
      js = quot;
    end else begin
      ks = k;
      js = quot;
    end
    sum_next = SUM_W'(day) + SUM_W'(month_term(month)) + SUM_W'(ks) + SUM_W'(ks[6:2])
             + SUM_W'(js[7:2]) + SUM_W'({js, 2'b00}) + SUM_W'(js);
    ok_next = 1'b1;
    if (year == '0) begin
      ok_next = 1'b0;
    end else if (day == '0) begin
      ok_next = 1'b0;
    end else if (month < MONTH_JAN || month > MONTH_DEC) begin
      ok_next = 1'b0;
    end else if (month == MONTH_FEB && day > 5'd29) begin
      ok_next = 1'b0;
    end else if (feb29 && !leap) begin
      ok_next = 1'b0;
    end else if (day == 5'd31 &&
                 (month inside {MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV})) begin
      ok_next = 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    job_push = 1'b0;
    case (state)
      F_IDLE: begin
        if (push) state_next = F_DIV;
      end
      F_DIV:  state_next = F_SUM;
      F_SUM:  state_next = F_PUSH;
      F_PUSH: begin
        if (!job_full) begin
          job_push = 1'b1;
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    job.ok = ok;
    job.wd = ok ? mod7(sum) : '0;
    job.feb29 = feb29;
    job.early = early;
    job.year = year;
    job.last = last;
    job.c100 = c100;
    job.c400 = c400;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && push) begin
      year <= date_year;
      month <= date_month;
      day <= date_day;
      last <= last_year;
    end
    if (state == F_DIV) begin
      quot <= prod[RECIP_SHIFT +: 8];
    end
    if (state == F_SUM) begin
      sum <= sum_next;
      ok <= ok_next;
      c100 <= k;
      c400 <= 9'({7'd0, quot[1:0]} * 9'd100) + 9'(k);
    end
  end

endmodule

@@ hw/rtl/wac_queue.sv @@
// Two-entry queue of job words between the front end and the scanner.
// Depends on wac_pkg.
module wac_queue import wac_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);

  job_t                slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;
  logic                do_push;
  logic                do_pop;

  assign full = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign pop_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_job;
  end

endmodule

@@ hw/rtl/wac_scan.sv @@
// Scanner: walks the later years one per cycle, tracks the weekday of the
// anniversary and counts matches; holds the result word. Depends on wac_pkg.
module wac_scan import wac_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_empty,
  output logic               job_pop,
  input  job_t               job,
  output logic               empty,
  input  logic               pop,
  output logic               date_ok,
  output logic [WD_W-1:0]    day_of_week,
  output logic [YEAR_W-1:0]  match_count
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_SCAN = 3'b010,
    B_DONE = 3'b100
  } bstate_t;

  bstate_t state;
  logic    res_valid;

  logic              ok;
  logic [WD_W-1:0]   wd_start;
  logic [WD_W-1:0]   wd_cur;
  logic              feb29;
  logic              early;
  logic [YEAR_W-1:0] y_cur;
  logic [YEAR_W-1:0] last;
  logic [6:0]        c100;
  logic [8:0]        c400;
  logic [YEAR_W-1:0] count;

  logic [YEAR_W:0]   cand;
  logic              leap_t;
  logic              leap_cur;
  logic [WD_W:0]     wd_sum;
  logic [WD_W-1:0]   wd_next;
  logic              write_res;

  assign empty = !res_valid;
  assign cand = {1'b0, y_cur} + 1'b1;
  assign leap_t = (y_cur[1:0] == 2'd3) && (c100 != 7'd99 || c400 == 9'd399);
  assign leap_cur = (y_cur[1:0] == 2'd0) && (c100 != 7'd0 || c400 == 9'd0);
  assign wd_sum = {1'b0, wd_cur} + 4'd1 + 4'(early ? leap_cur : leap_t);
  assign wd_next = (wd_sum >= 4'd7) ? 3'(wd_sum - 4'd7) : wd_sum[2:0];
  assign job_pop = (state == B_IDLE) && !job_empty;
  assign write_res = (state == B_DONE) && (!res_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      res_valid <= 1'b0;
    end else begin
      case (state)
        B_IDLE: begin
          if (!job_empty) state <= job.ok ? B_SCAN : B_DONE;
        end
        B_SCAN: begin
          if (cand > {1'b0, last}) state <= B_DONE;
        end
        B_DONE: begin
          if (write_res) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
      if (write_res) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      ok <= job.ok;
      wd_start <= job.wd;
      wd_cur <= job.wd;
      feb29 <= job.feb29;
      early <= job.early;
      y_cur <= job.year;
      last <= (job.last > MAX_YEAR) ? MAX_YEAR : job.last;
      c100 <= job.c100;
      c400 <= job.c400;
      count <= '0;
    end else if (state == B_SCAN && cand <= {1'b0, last}) begin
      y_cur <= cand[YEAR_W-1:0];
      wd_cur <= wd_next;
      c100 <= (c100 == 7'd99) ? 7'd0 : c100 + 7'd1;
      c400 <= (c400 == 9'd399) ? 9'd0 : c400 + 9'd1;
      if (!(feb29 && !leap_t) && wd_next == wd_start) count <= count + 1'b1;
    end
    if (write_res) begin
      date_ok <= ok;
      day_of_week <= wd_start;
      match_count <= count;
    end
  end

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for weekday_anniversary_counter. Depends on wac_pkg.
// Runs directed dates and then random ones, and checks every result word against its row's
// typed verdict or an in-bench model of the date check, Zeller weekday and anniversary scan.
module tb import wac_pkg::*; ();

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int RANDOM_WORDS = 75;
  localparam int N_DIRECTED = 25;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [YEAR_W-1:0]  last;
  } date_word_t;

  typedef struct packed {
    logic              ok;
    logic [WD_W-1:0]   wd;
    logic [YEAR_W-1:0] count;
  } verdict_t;

  typedef struct packed {
    date_word_t w;
    logic       typed;
    verdict_t   v;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic [YEAR_W-1:0]  date_year = '0;
  logic [MONTH_W-1:0] date_month = '0;
  logic [DAY_W-1:0]   date_day = '0;
  logic [YEAR_W-1:0]  last_year = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic               date_ok;
  logic [WD_W-1:0]    day_of_week;
  logic [YEAR_W-1:0]  match_count;

  verdict_t pending_verdicts[$];
  bit       calm = 1'b0;
  int       mismatches = 0;
  int       words_sent = 0;
  int       valid_dates = 0;
  int       results_seen = 0;
  int       cycle_count = 0;

  // Every row with typed set carries a result that is plain from the date alone.
  dir_row_t dir_rows [N_DIRECTED] = '{
    '{'{14'd0,     4'd1,  5'd1,  14'd2000},  1'b1, '{1'b0, 3'd0, 14'd0}},
    '{'{14'd2000,  4'd1,  5'd1,  14'd2000},  1'b1, '{1'b1, 3'd0, 14'd0}},
    '{'{14'd2024,  4'd1,  5'd1,  14'd2024},  1'b1, '{1'b1, 3'd2, 14'd0}},
    '{'{14'd2024,  4'd5,  5'd0,  14'd2030},  1'b1, '{1'b0, 3'd0, 14'd0}},
    '{'{14'd2024,  4'd0,  5'd10, 14'd2030},  1'b1, '{1'b0, 3'd0, 14'd0}},
    '{'{14'd2024,  4'd13, 5'd10, 14'd2030},  1'b1, '{1'b0, 3'd0, 14'd0}},
    '{'{14'd9999,  4'd15, 5'd31, 14'd16383}, 1'b1, '{1'b0, 3'd0, 14'd0}},
    '{'{14'd2023,  4'd4,  5'd31, 14'd2030},  1'b1, '{1'b0, 3'd0, 14'd0}},
    '{'{14'd2023,  4'd6,  5'd31, 14'd2030},  1'b1, '{1'b0, 3'd0, 14'd0}},
    '{'{14'd2023,  4'd9,  5'd31, 14'd2030},  1'b1, '{1'b0, 3'd0, 14'd0}},
    '{'{14'd2023,  4'd11, 5'd31, 14'd2030},  1'b1, '{1'b0, 3'd0, 14'd0}},
    '{'{14'd2024,  4'd2,  5'd30, 14'd2030},  1'b1, '{1'b0, 3'd0, 14'd0}},
    '{'{14'd2024,  4'd2,  5'd31, 14'd2030},  1'b1, '{1'b0, 3'd0, 14'd0}},
    '{'{14'd1900,  4'd2,  5'd29, 14'd2000},  1'b1, '{1'b0, 3'd0, 14'd0}},
    '{'{14'd2023,  4'd2,  5'd29, 14'd2030},  1'b1, '{1'b0, 3'd0, 14'd0}},
    '{'{14'd2000,  4'd2,  5'd29, 14'd2100},  1'b0, '{1'b0, 3'd0, 14'd0}},
    '{'{14'd2024,  4'd2,  5'd29, 14'd2060},  1'b0, '{1'b0, 3'd0, 14'd0}},
    '{'{14'd1,     4'd1,  5'd1,  14'd40},    1'b0, '{1'b0, 3'd0, 14'd0}},
    '{'{14'd1,     4'd12, 5'd31, 14'd0},     1'b0, '{1'b0, 3'd0, 14'd0}},
    '{'{14'd2020,  4'd3,  5'd15, 14'd100},   1'b0, '{1'b0, 3'd0, 14'd0}},
    '{'{14'd9999,  4'd12, 5'd31, 14'd16383}, 1'b0, '{1'b0, 3'd0, 14'd0}},
    '{'{14'd16383, 4'd12, 5'd31, 14'd16383}, 1'b0, '{1'b0, 3'd0, 14'd0}},
    '{'{14'd1,     4'd7,  5'd4,  14'd16383}, 1'b0, '{1'b0, 3'd0, 14'd0}},
    '{'{14'd4,     4'd2,  5'd29, 14'd9999},  1'b0, '{1'b0, 3'd0, 14'd0}},
    '{'{14'd2023,  4'd1,  5'd31, 14'd2100},  1'b0, '{1'b0, 3'd0, 14'd0}}
  };

  weekday_anniversary_counter dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .date_year(date_year),
    .date_month(date_month),
    .date_day(date_day),
    .last_year(last_year),
    .empty(empty),
    .pop(pop),
    .date_ok(date_ok),
    .day_of_week(day_of_week),
    .match_count(match_count)
  );

  always #6 clk = ~clk;

  function automatic bit leap_year(input int unsigned y);
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  function automatic int unsigned zeller_weekday(input int unsigned y, m, d);
    int unsigned mm, yy;
    mm = m;
    yy = y;
    if (mm < 3) begin
      mm += 12;
      yy -= 1;
    end
    return (d + (13 * (mm + 1)) / 5 + yy % 100 + (yy % 100) / 4 + (yy / 100) / 4
            + 5 * (yy / 100)) % 7;
  endfunction

  function automatic verdict_t predict_verdict(input date_word_t w);
    verdict_t v;
    int unsigned y, m, d, stop, wd, hits, t;
    y = w.year;
    m = w.month;
    d = w.day;
    stop = w.last;
    v = '0;
    if (y == 0 || d == 0 || m == 0 || m > MONTH_DEC) return v;
    if (m == MONTH_FEB && (d > 29 || (d == 29 && !leap_year(y)))) return v;
    if (d == 31 && (m inside {MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV}))
      return v;
    wd = zeller_weekday(y, m, d);
    if (stop > MAX_YEAR) stop = MAX_YEAR;
    hits = 0;
    for (t = y + 1; t <= stop; t++) begin
      if (m == MONTH_FEB && d == 29 && !leap_year(t)) continue;
      if (zeller_weekday(t, m, d) == wd) hits++;
    end
    v.ok = 1'b1;
    v.wd = WD_W'(wd);
    v.count = YEAR_W'(hits);
    return v;
  endfunction

  // Mostly well-formed dates with short scans, a few full-length scans, and
  // a quarter of the words with every field fully random.
  function automatic date_word_t random_word();
    date_word_t w;
    int unsigned pick, mdays;
    pick = $urandom_range(0, 99);
    w.year = YEAR_W'($urandom_range(1, 9999));
    w.month = MONTH_W'($urandom_range(1, 12));
    case (w.month)
      MONTH_FEB: begin
        mdays = leap_year(w.year) ? 29 : 28;
      end
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: begin
        mdays = 30;
      end
      default: begin
        mdays = 31;
      end
    endcase
    w.day = DAY_W'($urandom_range(1, mdays));
    if (pick < 5) begin
      w.last = YEAR_W'($urandom_range(0, 16383));
    end else if (pick < 75) begin
      w.last = YEAR_W'(w.year + $urandom_range(0, 30));
    end else begin
      w.year = YEAR_W'($urandom);
      w.month = MONTH_W'($urandom);
      w.day = DAY_W'($urandom);
      w.last = YEAR_W'($urandom);
    end
    return w;
  endfunction

  task automatic send_word(input date_word_t w, input logic typed, input verdict_t v);
    verdict_t exp_v;
    while (!calm && $urandom_range(0, 99) < 18) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    date_year <= w.year;
    date_month <= w.month;
    date_day <= w.day;
    last_year <= w.last;
    @(posedge clk);
    while (full) @(posedge clk);
    exp_v = typed ? v : predict_verdict(w);
    if (exp_v.ok) valid_dates++;
    pending_verdicts.push_back(exp_v);
    words_sent++;
  endtask

  task automatic drain_pending();
    push <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].v);
    drain_pending();
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      calm = (i >= 40 && i < 70);
      if (i == 70) drain_pending();
      send_word(random_word(), 1'b0, '0);
    end
    calm = 1'b0;
    drain_pending();
    repeat (20) @(posedge clk);
    if (pending_verdicts.size() != 0) mismatches++;
    $display("Sent %0d date words (%0d valid dates), checked %0d result words, %0d mismatches.",
             words_sent, valid_dates, results_seen, mismatches);
    if (mismatches == 0) begin
      $display("** weekday_anniversary_counter: PASSED **");
    end else begin
      $display("** weekday_anniversary_counter: FAILED **");
    end
    $finish;
  end

  initial begin : result_check
    verdict_t exp_v;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        results_seen++;
        if (pending_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result word: ok=%0b wd=%0d count=%0d",
                     date_ok, day_of_week, match_count);
        end else begin
          exp_v = pending_verdicts.pop_front();
          if (date_ok !== exp_v.ok || day_of_week !== exp_v.wd
              || match_count !== exp_v.count) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"Result word %0d: expected ok=%0b wd=%0d count=%0d, ",
                        "got ok=%0b wd=%0d count=%0d"},
                       results_seen, exp_v.ok, exp_v.wd, exp_v.count,
                       date_ok, day_of_week, match_count);
          end
        end
      end
      pop <= !rst && (calm || $urandom_range(0, 99) >= 18);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, pending_verdicts.size());
      $display("** weekday_anniversary_counter: FAILED **");
      $finish;
    end
  end

endmodule

@@ files.f @@
hw/rtl/wac_pkg.sv
hw/rtl/wac_front.sv
hw/rtl/wac_queue.sv
hw/rtl/wac_scan.sv
hw/rtl/weekday_anniversary_counter.sv
verif/tb.sv
